// ===== src/assert_macros.svh =====
// ============================================================================
// Assertion macros
// Short forms for the concurrent checks used in the list engine RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define OLE_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ordered list engine: assertion failed");

// next-cycle implication
`define OLE_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ordered list engine: assertion failed");

`endif

// ===== src/ole_pkg.sv =====
// ============================================================================
// ole_pkg
// Types and codes shared by the ordered list engine files.
// ============================================================================
package ole_pkg;

   localparam int WORD_W = 32;
   // index width of the cell control bus, enough for the largest list
   localparam int AT_W   = 10;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic [2:0]               cmd_type;
   typedef logic [1:0]               status_type;
   typedef logic [1:0]               mode_type;

   localparam cmd_type CMD_PUSH_FRONT = 3'd0;
   localparam cmd_type CMD_PUSH_BACK  = 3'd1;
   localparam cmd_type CMD_POP_FRONT  = 3'd2;
   localparam cmd_type CMD_POP_BACK   = 3'd3;
   localparam cmd_type CMD_INSERT_AT  = 3'd4;
   localparam cmd_type CMD_REMOVE_AT  = 3'd5;
   localparam cmd_type CMD_SEARCH     = 3'd6;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_FULL  = 2'd2;
   localparam status_type ST_RANGE = 2'd3;

   // cell row operations
   localparam mode_type MODE_HOLD   = 2'd0;
   localparam mode_type MODE_ROTATE = 2'd1;
   localparam mode_type MODE_INSERT = 2'd2;
   localparam mode_type MODE_REMOVE = 2'd3;

   typedef struct packed {
      mode_type          mode;
      logic [AT_W-1:0]   at;
   } cell_ctl_type;

endpackage

// ===== src/ole_if.sv =====
// ============================================================================
// ole_req_if / ole_rsp_if
// Valid/ready channels for command beats and result beats.
// ============================================================================
interface ole_req_if;
   logic               valid;
   logic               ready;
   ole_pkg::cmd_type   command;
   logic [4:0]         position;
   ole_pkg::word_type  value;

   modport source (output valid, output command, output position, output value,
                   input ready);
   modport sink   (input valid, input command, input position, input value,
                   output ready);
endinterface

interface ole_rsp_if;
   logic                valid;
   logic                ready;
   ole_pkg::word_type   removed_value;
   logic                found;
   ole_pkg::status_type status;
   logic [4:0]          count;

   modport source (output valid, output removed_value, output found, output status,
                   output count, input ready);
   modport sink   (input valid, input removed_value, input found, input status,
                   input count, output ready);
endinterface

// ===== src/ole_cell.sv =====
// ============================================================================
// ole_cell
// One list slot: holds a word, rotates, or shifts toward either neighbor.
// ============================================================================
module ole_cell #(
   parameter int CELL_IDX = 0
) (
   input  logic                  clock,
   input  ole_pkg::cell_ctl_type ctl,
   input  ole_pkg::word_type     ins_value,
   input  ole_pkg::word_type     left_data,
   input  ole_pkg::word_type     right_data,
   output ole_pkg::word_type     data
);

   localparam logic [ole_pkg::AT_W-1:0] MY_IDX = ole_pkg::AT_W'(CELL_IDX);

   ole_pkg::word_type data_ff;
   ole_pkg::word_type data_in;

   always_comb begin
      unique case (ctl.mode)
         ole_pkg::MODE_HOLD: begin
            data_in = data_ff;
         end
         ole_pkg::MODE_ROTATE: begin
            data_in = right_data;
         end
         ole_pkg::MODE_INSERT: begin
            if (MY_IDX == ctl.at) begin
               data_in = ins_value;
            end else if (MY_IDX > ctl.at) begin
               data_in = left_data;
            end else begin
               data_in = data_ff;
            end
         end
         ole_pkg::MODE_REMOVE: begin
            data_in = (MY_IDX >= ctl.at) ? right_data : data_ff;
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ===== src/ordered_list_engine_top.sv =====
// Sequence: push, pop front, insert and any rejected command go from IDLE
//   through APPLY and FIN; pop back, remove at and search first pass SCAN,
//   which rotates the whole cell ring once past cell 0. FIN waits for a free output reg.
// Flow: one command in flight; the next is taken once FIN loads the output reg.
// Reset (synchronous, active high): list empty, sequencer idle, no result
//   pending. Cell contents are not cleared.
// ============================================================================
// ordered_list_engine_top
// Bounded ordered list of signed words kept in a ring of shifting cells.
// ============================================================================
`include "assert_macros.svh"

module ordered_list_engine_top #(
   parameter int DEPTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   ole_req_if.sink   req_ch,
   ole_rsp_if.source rsp_ch
);

   // ---- widths -------------------------------------------------------------
   localparam int IDX_W  = $clog2(DEPTH);          // slot index
   localparam int FILL_W = $clog2(DEPTH + 1);      // element count
   localparam int CMP_W  = (FILL_W > 5) ? FILL_W : 5;  // count vs position
   localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(DEPTH - 1);

   // ---- sequencer codes ----------------------------------------------------
   // IDLE: take a command beat. SCAN: rotate the ring once, watching cell 0.
   // APPLY: shift the row and settle the result. FIN: hand it to the output reg.
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_APPLY = 2'd2;
   localparam logic [1:0] S_FIN   = 2'd3;

   // ---- control state ------------------------------------------------------
   logic [1:0]        state_ff, state_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0]  scan_cnt_ff, scan_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // ---- command held for the duration of its work --------------------------
   ole_pkg::cmd_type    cmd_ff, cmd_in;
   logic [IDX_W-1:0]    at_ff, at_in;
   ole_pkg::word_type   val_ff, val_in;
   ole_pkg::status_type st_ff, st_in;

   // ---- scan results and pending result ------------------------------------
   ole_pkg::word_type   take_ff, take_in;
   logic                hit_ff, hit_in;
   ole_pkg::word_type   res_removed_ff, res_removed_in;
   logic                res_found_ff, res_found_in;

   // ---- output register ----------------------------------------------------
   ole_pkg::word_type   rsp_removed_ff, rsp_removed_in;
   logic                rsp_found_ff, rsp_found_in;
   ole_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [4:0]          rsp_count_ff, rsp_count_in;

   // ---- decode of an incoming beat -----------------------------------------
   logic [CMP_W-1:0]    fill_x, pos_x, depth_x, dec_at_x;
   ole_pkg::status_type dec_status;
   logic                dec_scan;
   logic                req_take;
   logic                rsp_load;

   ole_pkg::cell_ctl_type ctl;
   ole_pkg::word_type     cell_data [DEPTH];

   assign fill_x   = CMP_W'(fill_ff);
   assign pos_x    = CMP_W'(req_ch.position);
   assign depth_x  = CMP_W'(DEPTH);
   assign req_take = req_ch.valid && req_ch.ready;

   // Range and capacity checks happen here, so later stages only act on
   // commands that are known to succeed.
   always_comb begin
      dec_at_x   = '0;
      dec_status = ole_pkg::ST_OK;
      dec_scan   = 1'b0;
      unique case (req_ch.command)
         ole_pkg::CMD_PUSH_FRONT, ole_pkg::CMD_PUSH_BACK, ole_pkg::CMD_INSERT_AT: begin
            if (req_ch.command == ole_pkg::CMD_PUSH_FRONT) begin
               dec_at_x = '0;
            end else if (req_ch.command == ole_pkg::CMD_PUSH_BACK) begin
               dec_at_x = fill_x;
            end else begin
               dec_at_x = pos_x;
            end
            if (fill_x == depth_x) begin
               dec_status = ole_pkg::ST_FULL;
            end else if (dec_at_x > fill_x) begin
               dec_status = ole_pkg::ST_RANGE;
            end
         end
         ole_pkg::CMD_POP_FRONT, ole_pkg::CMD_POP_BACK, ole_pkg::CMD_REMOVE_AT: begin
            if (req_ch.command == ole_pkg::CMD_POP_FRONT) begin
               dec_at_x = '0;
            end else if (req_ch.command == ole_pkg::CMD_POP_BACK) begin
               dec_at_x = fill_x - CMP_W'(1);
            end else begin
               dec_at_x = pos_x;
            end
            if (fill_x == '0) begin
               dec_status = ole_pkg::ST_EMPTY;
            end else if (dec_at_x >= fill_x) begin
               dec_status = ole_pkg::ST_RANGE;
            end else begin
               // pop front reads cell 0 directly; the others need the scan
               dec_scan = (req_ch.command != ole_pkg::CMD_POP_FRONT);
            end
         end
         ole_pkg::CMD_SEARCH: begin
            dec_scan = 1'b1;
         end
         default: begin
            // unused code: no change, status ok
         end
      endcase
   end

   // ---- sequencer ----------------------------------------------------------
   always_comb begin
      state_in       = state_ff;
      fill_in        = fill_ff;
      scan_cnt_in    = scan_cnt_ff;
      cmd_in         = cmd_ff;
      at_in          = at_ff;
      val_in         = val_ff;
      st_in          = st_ff;
      take_in        = take_ff;
      hit_in         = hit_ff;
      res_removed_in = res_removed_ff;
      res_found_in   = res_found_ff;
      ctl.mode       = ole_pkg::MODE_HOLD;
      ctl.at         = ole_pkg::AT_W'(at_ff);
      rsp_load       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               cmd_in      = req_ch.command;
               at_in       = dec_at_x[IDX_W-1:0];
               val_in      = req_ch.value;
               st_in       = dec_status;
               hit_in      = 1'b0;
               scan_cnt_in = '0;
               state_in    = dec_scan ? S_SCAN : S_APPLY;
            end
         end
         S_SCAN: begin
            // cell 0 holds slot scan_cnt during this cycle
            ctl.mode = ole_pkg::MODE_ROTATE;
            if (scan_cnt_ff == at_ff) begin
               take_in = cell_data[0];
            end
            if ((CMP_W'(scan_cnt_ff) < fill_x) && (cell_data[0] == val_ff)) begin
               hit_in = 1'b1;
            end
            scan_cnt_in = scan_cnt_ff + IDX_W'(1);
            if (scan_cnt_ff == SCAN_LAST) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            res_removed_in = '0;
            res_found_in   = 1'b0;
            if (st_ff == ole_pkg::ST_OK) begin
               unique case (cmd_ff)
                  ole_pkg::CMD_PUSH_FRONT, ole_pkg::CMD_PUSH_BACK,
                  ole_pkg::CMD_INSERT_AT: begin
                     ctl.mode = ole_pkg::MODE_INSERT;
                     fill_in  = fill_ff + FILL_W'(1);
                  end
                  ole_pkg::CMD_POP_FRONT, ole_pkg::CMD_POP_BACK,
                  ole_pkg::CMD_REMOVE_AT: begin
                     ctl.mode       = ole_pkg::MODE_REMOVE;
                     fill_in        = fill_ff - FILL_W'(1);
                     res_removed_in = (cmd_ff == ole_pkg::CMD_POP_FRONT) ?
                                      cell_data[0] : take_ff;
                  end
                  ole_pkg::CMD_SEARCH: begin
                     res_found_in = hit_ff;
                  end
                  default: begin
                  end
               endcase
            end
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ---- output register ----------------------------------------------------
   always_comb begin
      rsp_removed_in = rsp_removed_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      if (rsp_load) begin
         rsp_removed_in = res_removed_ff;
         rsp_found_in   = res_found_ff;
         rsp_status_in  = st_ff;
         rsp_count_in   = fill_x[4:0];
         rsp_valid_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         scan_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         scan_cnt_ff  <= scan_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      at_ff          <= at_in;
      val_ff         <= val_in;
      st_ff          <= st_in;
      take_ff        <= take_in;
      hit_ff         <= hit_in;
      res_removed_ff <= res_removed_in;
      res_found_ff   <= res_found_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
   end

   // ---- cell ring: slot 0 at the front, last cell wraps back to cell 0 -----
   for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
      ole_cell #(
         .CELL_IDX (gi)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .ins_value  (val_ff),
         .left_data  (cell_data[(gi + DEPTH - 1) % DEPTH]),
         .right_data (cell_data[(gi + 1) % DEPTH]),
         .data       (cell_data[gi])
      );
   end

   // ---- ports --------------------------------------------------------------
   assign req_ch.ready         = (state_ff == S_IDLE);
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.removed_value = rsp_removed_ff;
   assign rsp_ch.found         = rsp_found_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.count         = rsp_count_ff;

   // ---- checks -------------------------------------------------------------
   `OLE_ASSERT_IMP(a_fill_bound, clock, reset, 1'b1, fill_ff <= FILL_W'(DEPTH))
   `OLE_ASSERT_NXT(a_fill_only_in_apply, clock, reset, state_ff != S_APPLY, fill_ff == $past(fill_ff))
   `OLE_ASSERT_IMP(a_full_means_full, clock, reset, (state_ff == S_FIN) && (st_ff == ole_pkg::ST_FULL), fill_ff == FILL_W'(DEPTH))
   `OLE_ASSERT_NXT(a_scan_exit, clock, reset, (state_ff == S_SCAN) && (scan_cnt_ff == SCAN_LAST), state_ff == S_APPLY)
   `OLE_ASSERT_IMP(a_rsp_from_fin, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_FIN)

endmodule

// ===== tb/sv/ole_list_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ole_list_checker
// Watches the command and result channels of the ordered list engine. Every
// accepted command beat is run through a behavioral copy of the list, and the
// outcome is queued. Each result beat is compared field by field with the
// oldest queued outcome. Mismatches are counted for the testbench top.
// ============================================================================
module ole_list_checker #(
   parameter int DEPTH = 16
) (
   input  logic clock,
   input  logic reset,
   ole_req_if   req_ch,
   ole_rsp_if   rsp_ch,
   output int   mismatches,
   output int   results_owed
);

   typedef struct packed {
      ole_pkg::word_type   removed_value;
      logic                found;
      ole_pkg::status_type status;
      logic [4:0]          count;
   } list_result_type;

   // behavioral copy of the list, element 0 at the front
   ole_pkg::word_type list_words [DEPTH];
   int                list_len;
   list_result_type   owed_results [$];

   task automatic report_mismatch(input string what);
      $display("[%0t] list engine mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   function automatic list_result_type predict_list_result(input ole_pkg::cmd_type cmd,
                                                           input logic [4:0] pos,
                                                           input ole_pkg::word_type val);
      list_result_type r;
      int at;
      r = '0;
      case (cmd)
         ole_pkg::CMD_PUSH_FRONT, ole_pkg::CMD_PUSH_BACK, ole_pkg::CMD_INSERT_AT: begin
            if (list_len >= DEPTH) begin
               r.status = ole_pkg::ST_FULL;
            end else begin
               at = (cmd == ole_pkg::CMD_PUSH_FRONT) ? 0 :
                    (cmd == ole_pkg::CMD_PUSH_BACK)  ? list_len : int'(pos);
               if (at > list_len) begin
                  r.status = ole_pkg::ST_RANGE;
               end else begin
                  for (int i = list_len; i > at; i--) list_words[i] = list_words[i-1];
                  list_words[at] = val;
                  list_len++;
               end
            end
         end
         ole_pkg::CMD_POP_FRONT, ole_pkg::CMD_POP_BACK, ole_pkg::CMD_REMOVE_AT: begin
            if (list_len == 0) begin
               r.status = ole_pkg::ST_EMPTY;
            end else begin
               at = (cmd == ole_pkg::CMD_POP_FRONT) ? 0 :
                    (cmd == ole_pkg::CMD_POP_BACK)  ? list_len - 1 : int'(pos);
               if (at >= list_len) begin
                  r.status = ole_pkg::ST_RANGE;
               end else begin
                  r.removed_value = list_words[at];
                  for (int i = at; i < list_len - 1; i++) list_words[i] = list_words[i+1];
                  list_len--;
               end
            end
         end
         ole_pkg::CMD_SEARCH: begin
            for (int i = 0; i < list_len; i++)
               if (list_words[i] == val) r.found = 1'b1;
         end
         default: ;
      endcase
      r.count = list_len[4:0];
      return r;
   endfunction

   // values are sampled before this edge's updates land
   always @(posedge clock) begin
      list_result_type want;
      if (reset) begin
         owed_results.delete();
         list_len   = 0;
         mismatches = 0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            owed_results.push_back(predict_list_result(req_ch.command, req_ch.position,
                                                       req_ch.value));
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (owed_results.size() == 0) begin
               report_mismatch("result beat with no command outstanding");
            end else begin
               want = owed_results.pop_front();
               if (rsp_ch.removed_value !== want.removed_value)
                  report_mismatch($sformatf("removed_value got %0d want %0d",
                                            rsp_ch.removed_value, want.removed_value));
               if (rsp_ch.found !== want.found)
                  report_mismatch($sformatf("found got %b want %b",
                                            rsp_ch.found, want.found));
               if (rsp_ch.status !== want.status)
                  report_mismatch($sformatf("status got %0d want %0d",
                                            rsp_ch.status, want.status));
               if (rsp_ch.count !== want.count)
                  report_mismatch($sformatf("count got %0d want %0d",
                                            rsp_ch.count, want.count));
            end
         end
      end
      results_owed = owed_results.size();
   end

endmodule

// ===== tb/sv/tb_ordered_list_engine_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_ordered_list_engine_top
// Drives the ordered list engine with a directed opener (empty list, full
// list, bad positions, every command, extreme words) and then with random
// command beats whose mix swings between growing and shrinking the list.
// Both channels idle at random; one long result hold-off backs the engine up.
// The checker beside the engine predicts and compares every result beat.
// ============================================================================
module tb_ordered_list_engine_top;

   localparam int      DEPTH            = 16;
   localparam realtime CLK_PERIOD       = 12.0;
   localparam int      RANDOM_BEATS     = 1450;
   localparam int      CALM_BEATS       = 150;   // tail of the run with no idling
   localparam int      LONG_HOLD_AT     = 500;   // random beat that triggers the hold-off
   localparam int      LONG_HOLD_CYCLES = 300;
   localparam int      DRAIN_CYCLES     = DEPTH + 10;
   // command code the engine must ignore
   localparam ole_pkg::cmd_type CMD_UNUSED = 3'd7;

   logic clock;
   logic reset;
   int   mismatches;
   int   results_owed;
   bit   calm_phase;
   bit   hold_rsp_request;

   ole_req_if req_if ();
   ole_rsp_if rsp_if ();

   ordered_list_engine_top #(
      .DEPTH (DEPTH)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   ole_list_checker #(
      .DEPTH (DEPTH)
   ) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_if),
      .rsp_ch       (rsp_if),
      .mismatches   (mismatches),
      .results_owed (results_owed)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2.0) clock = ~clock;
   end

   // hard stop: several times the slowest legal run
   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // --------------------------------------------------------------------------
   // Command side
   // --------------------------------------------------------------------------

   // Offer one command beat; returns once it has been taken. A random idle
   // burst may come first, except in the calm tail.
   task automatic send_cmd(input ole_pkg::cmd_type cmd, input logic [4:0] pos,
                           input ole_pkg::word_type val);
      if (!calm_phase && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.command  <= cmd;
      req_if.position <= pos;
      req_if.value    <= val;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // Half the words come from a small pool so searches hit and duplicates occur.
   function automatic ole_pkg::word_type pick_word();
      ole_pkg::word_type pool [8];
      pool = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000, 32'shFFFF_FFFF,
               32'sh0000_0001, 32'sh5A5A_A5A5, 32'shA5A5_5A5A, 32'sh0000_0100};
      if ($urandom_range(0, 1) == 0) return pool[$urandom_range(0, 7)];
      return ole_pkg::word_type'($urandom);
   endfunction

   // Command mix biased toward growth or toward shrinking the list.
   function automatic ole_pkg::cmd_type pick_cmd(input bit growing);
      int roll;
      int grow_pct;
      roll     = $urandom_range(0, 99);
      grow_pct = growing ? 55 : 25;
      if (roll < grow_pct) begin
         case ($urandom_range(0, 2))
            0:       return ole_pkg::CMD_PUSH_FRONT;
            1:       return ole_pkg::CMD_PUSH_BACK;
            default: return ole_pkg::CMD_INSERT_AT;
         endcase
      end else if (roll < 87) begin
         case ($urandom_range(0, 2))
            0:       return ole_pkg::CMD_POP_FRONT;
            1:       return ole_pkg::CMD_POP_BACK;
            default: return ole_pkg::CMD_REMOVE_AT;
         endcase
      end else if (roll < 98) begin
         return ole_pkg::CMD_SEARCH;
      end
      return CMD_UNUSED;
   endfunction

   initial begin
      bit               growing;
      int               phase_left;
      ole_pkg::cmd_type cmd;
      logic [4:0]       pos;

      reset           = 1'b1;
      calm_phase      = 1'b0;
      hold_rsp_request = 1'b0;
      req_if.valid    <= 1'b0;
      req_if.command  <= ole_pkg::CMD_SEARCH;
      req_if.position <= '0;
      req_if.value    <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed opener ----
      // everything that needs an element fails on the empty list
      send_cmd(ole_pkg::CMD_SEARCH,    5'd0,  32'sh0000_0000);
      send_cmd(ole_pkg::CMD_POP_FRONT, 5'd0,  32'sh0000_0000);
      send_cmd(ole_pkg::CMD_POP_BACK,  5'd0,  32'sh0000_0000);
      send_cmd(ole_pkg::CMD_REMOVE_AT, 5'd0,  32'sh0000_0000);
      send_cmd(CMD_UNUSED,             5'd31, 32'shFFFF_FFFF);
      // insert past the end of a list that is not full
      send_cmd(ole_pkg::CMD_INSERT_AT, 5'd1,  32'sh1234_5678);
      // fill to capacity with a mix of front, back, middle and end inserts
      for (int i = 0; i < DEPTH; i++) begin
         ole_pkg::word_type w;
         w = (i == 0) ? 32'sh8000_0000 : (i == 1) ? 32'sh7FFF_FFFF :
             (i == 2) ? 32'shFFFF_FFFF : ole_pkg::word_type'($urandom);
         case (i % 3)
            0:       send_cmd(ole_pkg::CMD_PUSH_FRONT, 5'd0, w);
            1:       send_cmd(ole_pkg::CMD_PUSH_BACK,  5'd0, w);
            default: send_cmd(ole_pkg::CMD_INSERT_AT,
                              (i % 2 == 0) ? 5'(i) : 5'(i / 2), w);
         endcase
      end
      // overflow attempts leave the list alone
      send_cmd(ole_pkg::CMD_PUSH_FRONT, 5'd0,  32'sh0000_0001);
      send_cmd(ole_pkg::CMD_INSERT_AT,  5'd16, 32'sh0000_0001);
      send_cmd(ole_pkg::CMD_SEARCH,     5'd0,  32'sh7FFF_FFFF);
      send_cmd(ole_pkg::CMD_SEARCH,     5'd0,  32'sh0BAD_F00D);
      // remove at or beyond the count, then a legal remove at, pop back and pop front
      send_cmd(ole_pkg::CMD_REMOVE_AT,  5'd16, 32'sh0000_0000);
      send_cmd(ole_pkg::CMD_REMOVE_AT,  5'd31, 32'sh0000_0000);
      send_cmd(ole_pkg::CMD_REMOVE_AT,  5'd7,  32'sh0000_0000);
      send_cmd(ole_pkg::CMD_POP_BACK,   5'd0,  32'sh0000_0000);
      send_cmd(ole_pkg::CMD_POP_FRONT,  5'd0,  32'sh0000_0000);

      // ---- random part: phases alternate between growing and draining ----
      growing    = 1'b1;
      phase_left = $urandom_range(20, 60);
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (phase_left == 0) begin
            growing    = !growing;
            phase_left = $urandom_range(20, 60);
         end
         phase_left--;
         if (n == LONG_HOLD_AT) hold_rsp_request = 1'b1;
         if (n == RANDOM_BEATS - CALM_BEATS) calm_phase = 1'b1;
         cmd = pick_cmd(growing);
         // mostly legal-ish positions, sometimes any 5-bit value
         pos = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                           : 5'($urandom_range(0, DEPTH));
         send_cmd(cmd, pos, pick_word());
      end
      req_if.valid <= 1'b0;

      // wait for every owed result, then give stray beats a chance to appear
      while (results_owed != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // --------------------------------------------------------------------------
   // Result side: random back-pressure, plus one long hold-off that lets the
   // command side back up against a busy engine.
   // --------------------------------------------------------------------------
   initial begin
      rsp_if.ready <= 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if (hold_rsp_request) begin
            hold_rsp_request = 1'b0;
            rsp_if.ready <= 1'b0;
            for (int c = 0; c < LONG_HOLD_CYCLES; c++) @(posedge clock);
         end else if (!calm_phase && $urandom_range(0, 4) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

endmodule

// ===== ordered_list_engine_top.f =====
+incdir+src
src/ole_pkg.sv
src/ole_if.sv
src/ole_cell.sv
src/ordered_list_engine_top.sv
tb/sv/ole_list_checker.sv
tb/sv/tb_ordered_list_engine_top.sv
